>>> hdl/assert_macros.svh
// assertion macros for the pid filter slot table
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/pfst_pkg.sv
// types and constants for the pid filter slot table
// no dependencies
`timescale 1ns / 1ps
package pfst_pkg;

	localparam int PID_W = 13;
	localparam int REFS_W = 8;
	localparam int FIRST_GENERAL_SLOT = 4;

	localparam logic [PID_W-1:0] PID_NONE = 13'h0000;
	localparam logic [PID_W-1:0] PID_STOP_ONLY = 13'h1FFF;
	localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;
	localparam logic [REFS_W-1:0] TAP_COUNT = 8'd2;
	localparam logic [REFS_W-1:0] REFS_ONE = 8'd1;
	localparam logic [1:0] LAST_ROUTED_SLOT = 2'd2;

	localparam logic [2:0] KIND_OTHER = 3'd4;
	localparam logic [1:0] PES_OTHER = 2'd3;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_DEL = 1'b1;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_PROG = 2'd1;
	localparam logic [1:0] ACT_STOP = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NO_FREE = 2'd1;
	localparam logic [1:0] STAT_UNKNOWN = 2'd2;

	typedef struct packed {
		logic             req_type;
		logic [PID_W-1:0] pid;
		logic [2:0]       pid_kind;
	} req_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [3:0]        slot;
		logic [1:0]        pes_kind;
		logic              route_tap;
		logic [1:0]        status;
		logic [REFS_W-1:0] ref_count;
	} rsp_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [REFS_W-1:0] refs;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_APPLY,
		ST_DONE
	} state_t;

endpackage

>>> hdl/pid_filter_slot_table.sv
// pid filter slot table: reference-counted slot lookup, claim and release
// order: out_valid rises after the scan, drain, apply and done states that follow input accept;
// one word in flight, so a new word is accepted only after the last one has left ST_DONE, and
// the scan takes one slot per cycle of the table through its single read port and one shared compare unit
// a pid of zero skips the scan and goes straight to done with an all-zero response
// reset: asynchronous, active low; clears the table (valid bits), the state register and the hit, free and valid flags
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pid_filter_slot_table #(
	parameter int NUM_SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pfst_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output pfst_pkg::rsp_t out_data
);

	localparam int AW = $clog2(NUM_SLOTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);
	localparam logic [AW-1:0] GEN_IDX = AW'(pfst_pkg::FIRST_GENERAL_SLOT);

	pfst_pkg::state_t state_q, state_d;

	logic                          del_q;
	logic [pfst_pkg::PID_W-1:0]    pid_q;
	logic [2:0]                    kind_q;
	logic [AW-1:0]                 idx_q;
	logic                          cmp_vld_s1;
	logic [AW-1:0]                 cmp_idx_s1;
	logic                          hit_q;
	logic [AW-1:0]                 hit_idx_q;
	logic [pfst_pkg::REFS_W-1:0]   hit_refs_q;
	logic                          free_q;
	logic [AW-1:0]                 free_idx_q;
	pfst_pkg::rsp_t                res_q;
	pfst_pkg::rsp_t                out_q;
	logic                          out_valid_q;

	logic                  in_fire;
	logic                  done_go;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	pfst_pkg::slot_entry_t wr_data;
	pfst_pkg::slot_entry_t rd_data;
	pfst_pkg::rsp_t        apply_res;
	logic                  apply_wr;
	logic [2:0]            kind_clamp;

	pfst_slot_mem #(
		.NUM_SLOTS(NUM_SLOTS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(idx_q),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign in_fire = in_valid && in_ready;
	assign done_go = (state_q == pfst_pkg::ST_DONE) && (!out_valid_q || out_ready);
	assign kind_clamp = (in_data.pid_kind > pfst_pkg::KIND_OTHER) ?
		pfst_pkg::KIND_OTHER : in_data.pid_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			pfst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (in_data.pid == pfst_pkg::PID_NONE) ?
						pfst_pkg::ST_DONE : pfst_pkg::ST_SCAN;
				end
			end
			pfst_pkg::ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = pfst_pkg::ST_DRAIN;
				end
			end
			pfst_pkg::ST_DRAIN: begin
				state_d = pfst_pkg::ST_APPLY;
			end
			pfst_pkg::ST_APPLY: begin
				state_d = pfst_pkg::ST_DONE;
			end
			pfst_pkg::ST_DONE: begin
				if (done_go) begin
					state_d = pfst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfst_pkg::ST_IDLE;
			end
		endcase
	end

	// decision from the scan results
	always_comb begin
		logic [1:0]                  prog_act;
		logic                        routed;
		logic [pfst_pkg::REFS_W-1:0] refs_inc;
		logic [pfst_pkg::REFS_W-1:0] refs_dec;
		prog_act = (pid_q == pfst_pkg::PID_STOP_ONLY) ? pfst_pkg::ACT_STOP : pfst_pkg::ACT_PROG;
		routed = (hit_idx_q <= AW'(pfst_pkg::LAST_ROUTED_SLOT));
		refs_inc = (hit_refs_q == pfst_pkg::REFS_MAX) ? hit_refs_q :
			pfst_pkg::REFS_W'(hit_refs_q + pfst_pkg::REFS_ONE);
		refs_dec = (hit_refs_q == '0) ? hit_refs_q :
			pfst_pkg::REFS_W'(hit_refs_q - pfst_pkg::REFS_ONE);
		apply_res = '0;
		apply_wr = 1'b0;
		wr_addr = hit_idx_q;
		wr_data.pid = pid_q;
		wr_data.refs = pfst_pkg::REFS_ONE;
		if (del_q == pfst_pkg::REQ_ADD) begin
			if (hit_q) begin
				apply_wr = 1'b1;
				wr_data.refs = refs_inc;
				apply_res.slot = 4'(hit_idx_q);
				apply_res.ref_count = refs_inc;
				if (refs_inc == pfst_pkg::TAP_COUNT && routed) begin
					apply_res.action = prog_act;
					apply_res.pes_kind = 2'(hit_idx_q);
					apply_res.route_tap = 1'b1;
				end
			end else if (kind_q < pfst_pkg::KIND_OTHER) begin
				apply_wr = 1'b1;
				wr_addr = AW'(kind_q);
				apply_res.action = prog_act;
				apply_res.slot = 4'(kind_q);
				apply_res.ref_count = pfst_pkg::REFS_ONE;
				if (kind_q <= 3'(pfst_pkg::LAST_ROUTED_SLOT)) begin
					apply_res.pes_kind = 2'(kind_q);
					apply_res.route_tap = 1'b0;
				end else begin
					apply_res.pes_kind = pfst_pkg::PES_OTHER;
					apply_res.route_tap = 1'b1;
				end
			end else if (free_q) begin
				apply_wr = 1'b1;
				wr_addr = free_idx_q;
				apply_res.action = prog_act;
				apply_res.slot = 4'(free_idx_q);
				apply_res.ref_count = pfst_pkg::REFS_ONE;
				apply_res.pes_kind = pfst_pkg::PES_OTHER;
				apply_res.route_tap = 1'b1;
			end else begin
				apply_res.status = pfst_pkg::STAT_NO_FREE;
			end
		end else begin
			if (!hit_q) begin
				apply_res.status = pfst_pkg::STAT_UNKNOWN;
			end else begin
				apply_wr = 1'b1;
				wr_data.refs = refs_dec;
				apply_res.slot = 4'(hit_idx_q);
				apply_res.ref_count = refs_dec;
				if (refs_dec == '0) begin
					wr_data.pid = pfst_pkg::PID_NONE;
					apply_res.action = pfst_pkg::ACT_STOP;
				end else if (refs_dec == pfst_pkg::REFS_ONE && routed) begin
					apply_res.action = prog_act;
					apply_res.pes_kind = 2'(hit_idx_q);
					apply_res.route_tap = 1'b0;
				end
			end
		end
		// stream type and routing only mean something for a program command
		if (apply_res.action != pfst_pkg::ACT_PROG) begin
			apply_res.pes_kind = '0;
			apply_res.route_tap = 1'b0;
		end
	end

	assign wr_en = (state_q == pfst_pkg::ST_APPLY) && apply_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= (state_q == pfst_pkg::ST_SCAN);
			if (in_fire) begin
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end else if (cmp_vld_s1) begin
				if (!hit_q && rd_data.pid == pid_q) begin
					hit_q <= 1'b1;
				end
				if (!free_q && cmp_idx_s1 >= GEN_IDX && rd_data.refs == '0) begin
					free_q <= 1'b1;
				end
			end
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		if (in_fire) begin
			del_q <= in_data.req_type;
			pid_q <= in_data.pid;
			kind_q <= kind_clamp;
			idx_q <= '0;
			res_q <= '0;
		end else begin
			if (state_q == pfst_pkg::ST_SCAN) begin
				idx_q <= AW'(idx_q + 1'b1);
			end
			if (cmp_vld_s1) begin
				if (!hit_q && rd_data.pid == pid_q) begin
					hit_idx_q <= cmp_idx_s1;
					hit_refs_q <= rd_data.refs;
				end
				if (!free_q && cmp_idx_s1 >= GEN_IDX && rd_data.refs == '0) begin
					free_idx_q <= cmp_idx_s1;
				end
			end
			if (state_q == pfst_pkg::ST_APPLY) begin
				res_q <= apply_res;
			end
		end
		if (done_go) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`ASSERT_IMPL(a_no_prog_fields, clk, arst_n, out_valid && out_data.action != pfst_pkg::ACT_PROG, out_data.pes_kind == 2'd0 && out_data.route_tap == 1'b0)
	`ASSERT_IMPL(a_err_is_quiet, clk, arst_n, out_valid && out_data.status != pfst_pkg::STAT_OK, out_data.action == pfst_pkg::ACT_NONE && out_data.ref_count == '0)
	`ASSERT_NEXT(a_null_pid_skips, clk, arst_n, in_fire && in_data.pid == pfst_pkg::PID_NONE, state_q == pfst_pkg::ST_DONE && res_q == '0)

endmodule

>>> hdl/pfst_slot_mem.sv
// slot table storage: one write port, one registered read port, per-entry valid bits
// depends on pfst_pkg
`timescale 1ns / 1ps
module pfst_slot_mem #(
	parameter int NUM_SLOTS = 16,
	parameter int AW = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [AW-1:0]         rd_addr,
	output pfst_pkg::slot_entry_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  pfst_pkg::slot_entry_t wr_data
);

	pfst_pkg::slot_entry_t mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  vld_q;
	pfst_pkg::slot_entry_t rd_ent_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_ent_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// unwritten entries read as the reset value
	assign rd_data = rd_vld_q ? rd_ent_q : '0;

endmodule
